### rtl/tfsg_pkg.sv
// Shared types, constants and helper functions of the thermal frequency step governor.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package tfsg_pkg;

  localparam int CPU_COUNT      = 8;
  localparam int LEVELS_PER_CPU = 16;

  localparam int CPU_W       = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
  localparam int SLOT_W      = (LEVELS_PER_CPU > 1) ? $clog2(LEVELS_PER_CPU) : 1;
  localparam int LEVEL_DEPTH = CPU_COUNT * LEVELS_PER_CPU;
  localparam int ADDR_W      = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;

  localparam int FREQ_W   = 24;
  localparam int TEMP_W   = 18;
  localparam int ACTIVE_W = 4;

  localparam logic [CPU_W-1:0]  CPU_LAST  = CPU_W'(CPU_COUNT - 1);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LEVELS_PER_CPU - 1);

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LEVEL = 2'd1;
  localparam logic [1:0] OP_LIMIT = 2'd2;
  localparam logic [1:0] OP_CAP   = 2'd3;

  localparam logic [1:0] REG_THROTTLE   = 2'd0;
  localparam logic [1:0] REG_DETHROTTLE = 2'd1;
  localparam logic [1:0] REG_STEPWISE   = 2'd2;
  localparam logic [1:0] REG_ACTIVE     = 2'd3;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_THROTTLE   = 2'd1,
    ACT_DETHROTTLE = 2'd2
  } action_t;

  typedef struct packed {
    logic [TEMP_W-1:0]   throttle_temperature;
    logic [TEMP_W-1:0]   dethrottle_temperature;
    logic                stepwise_mode;
    logic [ACTIVE_W-1:0] active_cpus;
  } cfg_t;

  typedef struct packed {
    logic              accept;
    logic              start;
    logic              rd_en;
    logic              judge;
    logic              emit;
    logic [CPU_W-1:0]  cpu;
    logic [SLOT_W-1:0] slot;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t tick_dir;
    logic    out_free;
  } dp_stat_t;

  function automatic logic [CPU_W-1:0] governed_last(input logic [ACTIVE_W-1:0] active);
    logic [CPU_W-1:0] last;
    if (active == '0) begin
      last = '0;
    end else if (32'(active) > CPU_COUNT) begin
      last = CPU_LAST;
    end else begin
      last = CPU_W'(active - 1'b1);
    end
    return last;
  endfunction

  function automatic logic [ADDR_W-1:0] level_addr(input logic [CPU_W-1:0] cpu,
                                                   input logic [SLOT_W-1:0] slot);
    return ADDR_W'(32'(cpu) * LEVELS_PER_CPU + 32'(slot));
  endfunction

endpackage

`default_nettype wire

### rtl/thermal_frequency_step_governor.sv
// Top level of the thermal frequency step governor: stream ports, register port,
// and the sequencer, datapath and register file. Depends on tfsg_pkg, tfsg_cfg,
// tfsg_ctrl and tfsg_dp.
//
// Each CPU domain keeps a frequency cap, a 16-slot level table and hardware limits,
// all loaded by opcoded requests on the input stream, taken one per cycle when idle.
// A temperature tick compares against the two thresholds and, in stepwise mode, scans
// every governed CPU's level table through the table memory's single read port: each
// CPU passes through ST_SCAN over its slots, ST_DRAIN and ST_JUDGE; in direct mode
// each CPU passes through ST_JUDGE alone. Results are then emitted, waiting while the
// output stalls; a tick yields N results, N being the governed CPU count, the last
// flagged with tlast. A tick where no threshold is crossed skips the scan. Caps,
// limits and levels have no reset value and must be written before a tick uses them.
`default_nettype none

module thermal_frequency_step_governor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [17:0] temperature, [20:18] cpu_select, [24:21] level_slot, [25] level_present,
  // [49:26] frequency, [73:50] frequency_upper, [79:74] zero
  input  wire logic [79:0] in_tdata,
  // [1:0] opcode
  input  wire logic [1:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] cpu_number, [26:3] cap_now, [28:27] action, [29] cap_changed, [31:30] zero
  output logic [31:0]      out_tdata,
  output logic             out_tlast,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tfsg_pkg::*;

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  dp_stat_t   stat;
  logic [2:0]  res_cpu;
  logic [23:0] res_cap;
  logic [1:0]  res_act;
  logic        res_chg;

  tfsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  tfsg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_opcode (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tfsg_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .cmd                (cmd),
    .stat               (stat),
    .in_opcode          (in_tuser),
    .in_temperature     (in_tdata[17:0]),
    .in_cpu_select      (in_tdata[20:18]),
    .in_level_slot      (in_tdata[24:21]),
    .in_level_present   (in_tdata[25]),
    .in_frequency       (in_tdata[49:26]),
    .in_frequency_upper (in_tdata[73:50]),
    .out_valid          (out_tvalid),
    .out_ready          (out_tready),
    .out_cpu_number     (res_cpu),
    .out_cap_now        (res_cap),
    .out_action         (res_act),
    .out_cap_changed    (res_chg),
    .out_last_of_tick   (out_tlast)
  );

  assign out_tdata = {2'b00, res_chg, res_act, res_cap, res_cpu};

endmodule

`default_nettype wire

### rtl/tfsg_cfg.sv
// APB-style register file holding the governor's thresholds, mode and CPU count.
// Depends on tfsg_pkg.
`default_nettype none

module tfsg_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic      [31:0]         prdata,
  output logic                     pready,
  output tfsg_pkg::cfg_t           cfg
);
  import tfsg_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_THROTTLE:   cfg_nxt.throttle_temperature   = pwdata[TEMP_W-1:0];
        REG_DETHROTTLE: cfg_nxt.dethrottle_temperature = pwdata[TEMP_W-1:0];
        REG_STEPWISE:   cfg_nxt.stepwise_mode          = pwdata[0];
        REG_ACTIVE:     cfg_nxt.active_cpus            = pwdata[ACTIVE_W-1:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_THROTTLE:   prdata = 32'(cfg_r.throttle_temperature);
      REG_DETHROTTLE: prdata = 32'(cfg_r.dethrottle_temperature);
      REG_STEPWISE:   prdata = 32'(cfg_r.stepwise_mode);
      REG_ACTIVE:     prdata = 32'(cfg_r.active_cpus);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.throttle_temperature   <= TEMP_W'(80000);
      cfg_r.dethrottle_temperature <= TEMP_W'(70000);
      cfg_r.stepwise_mode          <= 1'b1;
      cfg_r.active_cpus            <= ACTIVE_W'(8);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/tfsg_ctrl.sv
// Sequencer of the governor: walks the CPUs and table slots of a tick and paces results.
// Depends on tfsg_pkg; drives the datapath tfsg_dp through command and status structs.
`default_nettype none

module tfsg_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  tfsg_pkg::cfg_t           cfg,
  input  wire logic                in_tvalid,
  input  wire logic [1:0]          in_opcode,
  output logic                     in_tready,
  input  tfsg_pkg::dp_stat_t       stat,
  output tfsg_pkg::ctrl_cmd_t      cmd
);
  import tfsg_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_JUDGE = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CPU_W-1:0]  cpu_r, cpu_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [CPU_W-1:0]  cpu_last;

  assign cpu_last  = governed_last(cfg.active_cpus);
  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cpu_nxt    = cpu_r;
    slot_nxt   = slot_r;
    cmd        = '0;
    cmd.cpu    = cpu_r;
    cmd.slot   = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        cmd.accept = in_tvalid;
        if (in_tvalid && (in_opcode == OP_TICK)) begin
          cmd.start = 1'b1;
          cpu_nxt   = '0;
          slot_nxt  = '0;
          priority if (stat.tick_dir == ACT_NONE) begin
            state_nxt = ST_EMIT;
          end else if (cfg.stepwise_mode) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_JUDGE;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        if (slot_r == SLOT_LAST) begin
          slot_nxt  = '0;
          state_nxt = ST_DRAIN;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_JUDGE;
      end
      ST_JUDGE: begin
        cmd.judge = 1'b1;
        if (cpu_r == cpu_last) begin
          cpu_nxt   = '0;
          state_nxt = ST_EMIT;
        end else begin
          cpu_nxt   = cpu_r + 1'b1;
          state_nxt = cfg.stepwise_mode ? ST_SCAN : ST_JUDGE;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (cpu_r == cpu_last) begin
            cpu_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            cpu_nxt = cpu_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cpu_r   <= '0;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cpu_r   <= cpu_nxt;
      slot_r  <= slot_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/tfsg_dp.sv
// Datapath of the governor: level table memory, per-CPU limits and caps, the scan
// accumulators, the decision logic and the output register. Depends on tfsg_pkg.
`default_nettype none

module tfsg_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  tfsg_pkg::cfg_t           cfg,
  input  tfsg_pkg::ctrl_cmd_t      cmd,
  output tfsg_pkg::dp_stat_t       stat,
  input  wire logic [1:0]          in_opcode,
  input  wire logic [17:0]         in_temperature,
  input  wire logic [2:0]          in_cpu_select,
  input  wire logic [3:0]          in_level_slot,
  input  wire logic                in_level_present,
  input  wire logic [23:0]         in_frequency,
  input  wire logic [23:0]         in_frequency_upper,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_cpu_number,
  output logic [23:0]              out_cap_now,
  output logic [1:0]               out_action,
  output logic                     out_cap_changed,
  output logic                     out_last_of_tick
);
  import tfsg_pkg::*;

  logic [FREQ_W-1:0]      level_mem [LEVEL_DEPTH];
  logic [LEVEL_DEPTH-1:0] level_vld_r;
  logic [FREQ_W-1:0]      rd_data_r;
  logic                   rd_vbit_r;
  logic                   rd_pend_r;

  logic [FREQ_W-1:0]      cap_r  [CPU_COUNT];
  logic [FREQ_W-1:0]      min_r  [CPU_COUNT];
  logic [FREQ_W-1:0]      max_r  [CPU_COUNT];
  logic [FREQ_W-1:0]      cand_r [CPU_COUNT];
  logic [CPU_COUNT-1:0]   cand_ok_r;

  action_t                dir_r;
  logic                   trig_any_r;

  logic                   any_r, any_nxt;
  logic                   found_r, found_nxt;
  logic [FREQ_W-1:0]      lo_r, lo_nxt;
  logic [FREQ_W-1:0]      hi_r, hi_nxt;
  logic [FREQ_W-1:0]      best_r, best_nxt;

  logic                   out_valid_r;
  logic [CPU_W-1:0]       out_cpu_r;
  logic [FREQ_W-1:0]      out_cap_r;
  action_t                out_act_r;
  logic                   out_chg_r;
  logic                   out_last_r;

  logic                   wr_cpu_ok;
  logic                   wr_level;
  logic                   wr_limit;
  logic                   wr_cap;
  logic [CPU_W-1:0]       wr_cpu;
  logic [ADDR_W-1:0]      wr_addr;
  logic [ADDR_W-1:0]      rd_addr;

  logic [FREQ_W-1:0]      cap_cur;
  logic [FREQ_W-1:0]      min_cur;
  logic [FREQ_W-1:0]      max_cur;
  logic                   absorb;

  logic                   j_trig;
  logic                   j_ok;
  logic [FREQ_W-1:0]      j_val;

  action_t                e_act;
  logic                   e_chg;
  logic [FREQ_W-1:0]      e_cap;

  assign wr_cpu_ok = (32'(in_cpu_select) < CPU_COUNT);
  assign wr_cpu    = CPU_W'(in_cpu_select);
  assign wr_level  = cmd.accept && (in_opcode == OP_LEVEL) && wr_cpu_ok &&
                     (32'(in_level_slot) < LEVELS_PER_CPU);
  assign wr_limit  = cmd.accept && (in_opcode == OP_LIMIT) && wr_cpu_ok;
  assign wr_cap    = cmd.accept && (in_opcode == OP_CAP) && wr_cpu_ok;
  assign wr_addr   = level_addr(wr_cpu, SLOT_W'(in_level_slot));
  assign rd_addr   = level_addr(cmd.cpu, cmd.slot);

  assign cap_cur = cap_r[cmd.cpu];
  assign min_cur = min_r[cmd.cpu];
  assign max_cur = max_r[cmd.cpu];

  always_comb begin
    if (in_temperature > cfg.throttle_temperature) begin
      stat.tick_dir = ACT_THROTTLE;
    end else if (in_temperature < cfg.dethrottle_temperature) begin
      stat.tick_dir = ACT_DETHROTTLE;
    end else begin
      stat.tick_dir = ACT_NONE;
    end
    stat.out_free = !out_valid_r || out_ready;
  end

  // Level table: one write port used by level writes, one registered read port for the scan.
  always_ff @(posedge clk) begin
    if (wr_level) begin
      level_mem[wr_addr] <= in_frequency;
    end
    if (cmd.rd_en) begin
      rd_data_r <= level_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_vld_r <= '0;
      rd_vbit_r   <= 1'b0;
      rd_pend_r   <= 1'b0;
    end else begin
      if (wr_level) begin
        level_vld_r[wr_addr] <= in_level_present;
      end
      rd_pend_r <= cmd.rd_en;
      rd_vbit_r <= level_vld_r[rd_addr];
    end
  end

  assign absorb = rd_pend_r && rd_vbit_r;

  always_comb begin
    any_nxt   = any_r;
    found_nxt = found_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    best_nxt  = best_r;
    if (cmd.start || cmd.judge) begin
      any_nxt   = 1'b0;
      found_nxt = 1'b0;
      lo_nxt    = '0;
      hi_nxt    = '0;
      best_nxt  = '0;
    end else if (absorb) begin
      any_nxt = 1'b1;
      if (!any_r || (rd_data_r < lo_r)) begin
        lo_nxt = rd_data_r;
      end
      if (!any_r || (rd_data_r > hi_r)) begin
        hi_nxt = rd_data_r;
      end
      if (dir_r == ACT_THROTTLE) begin
        if ((rd_data_r != '0) && (rd_data_r < cap_cur) && (rd_data_r > best_r)) begin
          best_nxt  = rd_data_r;
          found_nxt = 1'b1;
        end
      end else begin
        if ((rd_data_r > cap_cur) && (!found_r || (rd_data_r < best_r))) begin
          best_nxt  = rd_data_r;
          found_nxt = 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (cfg.stepwise_mode) begin
      j_trig = any_r && ((dir_r == ACT_THROTTLE) ? (cap_cur > lo_r) : (cap_cur < hi_r));
      j_ok   = found_r;
      j_val  = best_r;
    end else if (dir_r == ACT_THROTTLE) begin
      j_trig = cap_cur > min_cur;
      j_ok   = j_trig;
      j_val  = min_cur;
    end else begin
      j_trig = cap_cur < max_cur;
      j_ok   = 1'b1;
      j_val  = max_cur;
    end
  end

  assign e_act = trig_any_r ? dir_r : ACT_NONE;
  assign e_chg = (e_act != ACT_NONE) && cand_ok_r[cmd.cpu];
  assign e_cap = e_chg ? cand_r[cmd.cpu] : cap_cur;

  always_ff @(posedge clk) begin
    if (wr_limit) begin
      min_r[wr_cpu] <= in_frequency;
      max_r[wr_cpu] <= in_frequency_upper;
    end
    if (cmd.emit) begin
      cap_r[cmd.cpu] <= e_cap;
    end else if (wr_cap) begin
      cap_r[wr_cpu] <= in_frequency;
    end
    if (cmd.judge) begin
      cand_r[cmd.cpu] <= j_val;
    end
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    best_r <= best_nxt;
    if (cmd.emit) begin
      out_cpu_r  <= cmd.cpu;
      out_cap_r  <= e_cap;
      out_act_r  <= e_act;
      out_chg_r  <= e_chg;
      out_last_r <= (cmd.cpu == governed_last(cfg.active_cpus));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_ok_r   <= '0;
      dir_r       <= ACT_NONE;
      trig_any_r  <= 1'b0;
      any_r       <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      any_r   <= any_nxt;
      found_r <= found_nxt;
      if (cmd.start) begin
        dir_r      <= stat.tick_dir;
        trig_any_r <= 1'b0;
      end else if (cmd.judge) begin
        trig_any_r <= trig_any_r | j_trig;
      end
      if (cmd.judge) begin
        cand_ok_r[cmd.cpu] <= j_ok;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_cpu_number   = 3'(out_cpu_r);
  assign out_cap_now      = out_cap_r;
  assign out_action       = out_act_r;
  assign out_cap_changed  = out_chg_r;
  assign out_last_of_tick = out_last_r;

endmodule

`default_nettype wire
